// ----- src/vlcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vlcs_pkg;

    // Clipped coordinates stay inside [0, (SIZE-1) << FRAC_BITS]; 20 bits covers
    // raw 18-bit inputs, differences and the DDA walk past either edge.
    localparam int COORD_W  = 20;
    // Error terms are Q(3*FRAC_BITS) with headroom for the widest FRAC_BITS.
    localparam int ERR_W    = 40;
    // Slope quotient never exceeds 1 << (2*FRAC_BITS).
    localparam int SLOPE_W  = 25;
    // Divider dividend: |delta| << (2*FRAC_BITS) at the widest fraction.
    localparam int DIV_W    = 44;
    localparam int DIVCNT_W = 6;
    localparam int IDX_W    = 18;
    localparam int COLOUR_W = 8;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;
    localparam int CNT_W    = 7;
    localparam logic [CNT_W-1:0] MAX_OUT = 7'd64;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic [1:0]                axis_t;

    localparam axis_t AX_X = 2'd0;
    localparam axis_t AX_Y = 2'd1;
    localparam axis_t AX_Z = 2'd2;

    typedef struct packed {
        axis_t                maj;
        axis_t                mid;
        axis_t                mnr;
        coord_t               x;
        coord_t               x1;
        coord_t               y;
        coord_t               z;
        logic                 dy_neg;
        logic                 dz_neg;
        err_t                 ey;
        err_t                 ez;
        err_t                 ey_step;
        err_t                 ez_step;
        logic [COLOUR_W-1:0]  colour;
    } job_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [COORD_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quotient;
    } div_rsp_t;

    function automatic coord_t pick3(axis_t i, coord_t v0, coord_t v1, coord_t v2);
        coord_t r;
        case (i)
            AX_X:    r = v0;
            AX_Y:    r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/vlcs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module vlcs_div
    import vlcs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  div_req_t      req,
    output div_rsp_t      rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [DIVCNT_W-1:0] cnt_reg;
    logic [COORD_W-1:0]  rem_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [COORD_W-1:0]  dvs_reg;

    logic [COORD_W:0]    rem_sh;
    logic                bit_q;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign bit_q  = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIVCNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIVCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], bit_q};
            rem_reg <= bit_q ? COORD_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[COORD_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ----- src/vlcs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Front end: accept a segment, clip it, pick the major axis, work out the
// slopes and starting error terms, then queue a job if the segment survives.
module vlcs_front
    import vlcs_pkg::*;
#(
    parameter int SIZE_X    = 64,
    parameter int SIZE_Y    = 64,
    parameter int SIZE_Z    = 64,
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [17:0]   start_x,
    input  wire logic signed [17:0]   start_y,
    input  wire logic signed [17:0]   start_z,
    input  wire logic signed [17:0]   end_x,
    input  wire logic signed [17:0]   end_y,
    input  wire logic signed [17:0]   end_z,
    input  wire logic [COLOUR_W-1:0]  line_colour,
    output div_req_t                  div_req,
    input  div_rsp_t                  div_rsp,
    output logic                      push,
    output job_t                      push_job,
    input  wire logic                 q_full
);

    localparam int     HM_W  = FRAC_BITS + 2;
    localparam int     PRD_W = 2 * COORD_W;
    localparam coord_t MAX_X = coord_t'((SIZE_X - 1) << FRAC_BITS);
    localparam coord_t MAX_Y = coord_t'((SIZE_Y - 1) << FRAC_BITS);
    localparam coord_t MAX_Z = coord_t'((SIZE_Z - 1) << FRAC_BITS);
    localparam int     HALF  = 1 << (FRAC_BITS - 1);
    localparam err_t   G_ONE = err_t'(64'd1 << (3 * FRAC_BITS));

    typedef enum logic [10:0] {
        F_IDLE    = 11'b000_0000_0001,
        F_CHECK   = 11'b000_0000_0010,
        F_MUL     = 11'b000_0000_0100,
        F_DIVGO   = 11'b000_0000_1000,
        F_DIVWAIT = 11'b000_0001_0000,
        F_APPLY   = 11'b000_0010_0000,
        F_ORDER   = 11'b000_0100_0000,
        F_SETUP   = 11'b000_1000_0000,
        F_EMUL    = 11'b001_0000_0000,
        F_EFIN    = 11'b010_0000_0000,
        F_PUSH    = 11'b100_0000_0000
    } fstate_t;

    fstate_t state_reg, state_next;

    coord_t              a_reg [3];
    coord_t              b_reg [3];
    logic [COLOUR_W-1:0] colour_reg;
    axis_t               axis_reg;
    logic                side_reg;
    logic                jsel_reg;
    logic                swap_reg;
    logic                slope_reg;
    logic [DIV_W-1:0]    dvd_reg;
    logic [COORD_W-1:0]  dvs_reg;
    logic                qneg_reg;
    axis_t               maj_reg, mid_reg, mnr_reg;
    coord_t              x_reg, x1_reg, y_reg, z_reg;
    logic                dyneg_reg, dzneg_reg;
    logic [COORD_W-1:0]  adz_reg;
    logic [SLOPE_W-1:0]  edy_reg, edz_reg;
    err_t                py_reg, pz_reg;
    err_t                ey_reg, ez_reg;

    // clip helpers
    coord_t ac, bc, m_c, chk_lo, chk_hi, lo_c, hi_c, lo_j, hi_j, aj, bj;
    coord_t num, den, dj, qc, qsig, wv, cv;
    logic   swap_now, tb, last_axis;
    axis_t  oth;
    logic signed [PRD_W-1:0] prod;
    logic [PRD_W-1:0]        prod_mag;

    // order / setup helpers
    logic [COORD_W-1:0] dab0, dab1, dab2, d_t2, ady;
    logic   sw1, sw2, sa;
    axis_t  o_maj, o_mid, o_mnr, t2;
    coord_t s0, s1, s2, e0, e1, e2, sx, sx1, sy, sz, dx, dy, dz;

    // error term helpers
    logic signed [HM_W-1:0] hm;
    err_t ey0, ez0;

    assign ac        = pick3(axis_reg, a_reg[0], a_reg[1], a_reg[2]);
    assign bc        = pick3(axis_reg, b_reg[0], b_reg[1], b_reg[2]);
    assign m_c       = pick3(axis_reg, MAX_X, MAX_Y, MAX_Z);
    assign swap_now  = (ac > bc);
    assign chk_lo    = swap_now ? bc : ac;
    assign chk_hi    = swap_now ? ac : bc;
    assign last_axis = (axis_reg == AX_Z);

    assign oth  = jsel_reg ? ((axis_reg == AX_Z) ? AX_Y : AX_Z)
                           : ((axis_reg == AX_X) ? AX_Y : AX_X);
    assign aj   = pick3(oth, a_reg[0], a_reg[1], a_reg[2]);
    assign bj   = pick3(oth, b_reg[0], b_reg[1], b_reg[2]);
    assign lo_c = swap_reg ? bc : ac;
    assign hi_c = swap_reg ? ac : bc;
    assign lo_j = swap_reg ? bj : aj;
    assign hi_j = swap_reg ? aj : bj;
    assign num  = side_reg ? (hi_c - m_c) : (-lo_c);
    assign den  = hi_c - lo_c;
    assign dj   = hi_j - lo_j;
    assign prod = PRD_W'(dj) * PRD_W'(num);
    assign prod_mag = prod[PRD_W-1] ? PRD_W'(-prod) : PRD_W'(prod);

    assign qc   = coord_t'(div_rsp.quotient[COORD_W-1:0]);
    assign qsig = qneg_reg ? -qc : qc;
    assign wv   = side_reg ? (hi_j - qsig) : (lo_j + qsig);
    assign cv   = side_reg ? m_c : '0;
    // low side writes the low endpoint, high side the high one
    assign tb   = swap_reg ^ side_reg;

    function automatic logic [COORD_W-1:0] absd(coord_t p, coord_t q);
        coord_t t;
        t = p - q;
        return t[COORD_W-1] ? COORD_W'(-t) : COORD_W'(t);
    endfunction

    // compare-and-swap network: y against z, then x against the winner
    assign dab0  = absd(a_reg[0], b_reg[0]);
    assign dab1  = absd(a_reg[1], b_reg[1]);
    assign dab2  = absd(a_reg[2], b_reg[2]);
    assign sw1   = (dab1 > dab2);
    assign o_mid = sw1 ? AX_Z : AX_Y;
    assign t2    = sw1 ? AX_Y : AX_Z;
    assign d_t2  = sw1 ? dab1 : dab2;
    assign sw2   = (dab0 > d_t2);
    assign o_maj = sw2 ? AX_X : t2;
    assign o_mnr = sw2 ? t2 : AX_X;

    assign sa  = (pick3(maj_reg, a_reg[0], a_reg[1], a_reg[2]) <
                  pick3(maj_reg, b_reg[0], b_reg[1], b_reg[2]));
    assign s0  = sa ? a_reg[0] : b_reg[0];
    assign s1  = sa ? a_reg[1] : b_reg[1];
    assign s2  = sa ? a_reg[2] : b_reg[2];
    assign e0  = sa ? b_reg[0] : a_reg[0];
    assign e1  = sa ? b_reg[1] : a_reg[1];
    assign e2  = sa ? b_reg[2] : a_reg[2];
    assign sx  = pick3(maj_reg, s0, s1, s2);
    assign sx1 = pick3(maj_reg, e0, e1, e2);
    assign sy  = pick3(mid_reg, s0, s1, s2);
    assign sz  = pick3(mnr_reg, s0, s1, s2);
    assign dx  = sx1 - sx;
    assign dy  = pick3(mid_reg, e0, e1, e2) - sy;
    assign dz  = pick3(mnr_reg, e0, e1, e2) - sz;
    assign ady = dy[COORD_W-1] ? COORD_W'(-dy) : COORD_W'(dy);

    // start point is never negative after clipping, so frac is the low bits
    assign hm  = $signed(HM_W'(HALF)) - $signed({2'b00, x_reg[FRAC_BITS-1:0]});
    assign ey0 = py_reg + $signed(ERR_W'(y_reg[FRAC_BITS-1:0]) << (2 * FRAC_BITS));
    assign ez0 = pz_reg + $signed(ERR_W'(z_reg[FRAC_BITS-1:0]) << (2 * FRAC_BITS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (in_valid)
                    state_next = F_CHECK;
            F_CHECK:
                if (chk_hi < 0 || chk_lo > m_c)
                    state_next = F_IDLE;
                else if (chk_lo < 0 || chk_hi > m_c)
                    state_next = F_MUL;
                else if (last_axis)
                    state_next = F_ORDER;
            F_MUL:
                state_next = F_DIVGO;
            F_DIVGO:
                state_next = F_DIVWAIT;
            F_DIVWAIT:
                if (div_rsp.done)
                    state_next = F_APPLY;
            F_APPLY:
                if (slope_reg)
                    state_next = jsel_reg ? F_EMUL : F_DIVGO;
                else if (!jsel_reg)
                    state_next = F_MUL;
                else if (!side_reg && hi_c > m_c)
                    state_next = F_MUL;
                else if (last_axis)
                    state_next = F_ORDER;
                else
                    state_next = F_CHECK;
            F_ORDER:
                state_next = F_SETUP;
            F_SETUP:
                state_next = (dx <= 0) ? F_IDLE : F_DIVGO;
            F_EMUL:
                state_next = F_EFIN;
            F_EFIN:
                state_next = F_PUSH;
            F_PUSH:
                if (!q_full)
                    state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
                if (in_valid)
                begin
                    a_reg[0]   <= coord_t'(start_x);
                    a_reg[1]   <= coord_t'(start_y);
                    a_reg[2]   <= coord_t'(start_z);
                    b_reg[0]   <= coord_t'(end_x);
                    b_reg[1]   <= coord_t'(end_y);
                    b_reg[2]   <= coord_t'(end_z);
                    colour_reg <= line_colour;
                    axis_reg   <= AX_X;
                end
            F_CHECK:
            begin
                swap_reg  <= swap_now;
                side_reg  <= !(chk_lo < 0);
                jsel_reg  <= 1'b0;
                slope_reg <= 1'b0;
                if (!(chk_lo < 0) && !(chk_hi > m_c) && !last_axis)
                    axis_reg <= axis_reg + 2'd1;
            end
            F_MUL:
            begin
                dvd_reg  <= DIV_W'(prod_mag);
                dvs_reg  <= den[COORD_W-1:0];
                qneg_reg <= prod[PRD_W-1];
            end
            F_APPLY:
                if (slope_reg)
                begin
                    if (!jsel_reg)
                    begin
                        edy_reg  <= div_rsp.quotient[SLOPE_W-1:0];
                        dvd_reg  <= DIV_W'(adz_reg) << (2 * FRAC_BITS);
                        jsel_reg <= 1'b1;
                    end
                    else
                        edz_reg <= div_rsp.quotient[SLOPE_W-1:0];
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (axis_t'(k) == oth)
                        begin
                            if (tb) b_reg[k] <= wv;
                            else    a_reg[k] <= wv;
                        end
                        // clipped axis lands exactly on the face, written last
                        if (jsel_reg && axis_t'(k) == axis_reg)
                        begin
                            if (tb) b_reg[k] <= cv;
                            else    a_reg[k] <= cv;
                        end
                    end
                    if (!jsel_reg)
                        jsel_reg <= 1'b1;
                    else if (!side_reg && hi_c > m_c)
                    begin
                        side_reg <= 1'b1;
                        jsel_reg <= 1'b0;
                    end
                    else if (!last_axis)
                        axis_reg <= axis_reg + 2'd1;
                end
            F_ORDER:
            begin
                maj_reg <= o_maj;
                mid_reg <= o_mid;
                mnr_reg <= o_mnr;
            end
            F_SETUP:
            begin
                x_reg     <= sx;
                x1_reg    <= sx1;
                y_reg     <= sy;
                z_reg     <= sz;
                dyneg_reg <= dy[COORD_W-1];
                dzneg_reg <= dz[COORD_W-1];
                adz_reg   <= dz[COORD_W-1] ? COORD_W'(-dz) : COORD_W'(dz);
                dvd_reg   <= DIV_W'(ady) << (2 * FRAC_BITS);
                dvs_reg   <= dx[COORD_W-1:0];
                qneg_reg  <= 1'b0;
                slope_reg <= 1'b1;
                jsel_reg  <= 1'b0;
            end
            F_EMUL:
            begin
                py_reg <= ERR_W'(hm) * ERR_W'($signed({1'b0, edy_reg}));
                pz_reg <= ERR_W'(hm) * ERR_W'($signed({1'b0, edz_reg}));
            end
            F_EFIN:
            begin
                ey_reg <= dyneg_reg ? -ey0 : (ey0 - G_ONE);
                ez_reg <= dzneg_reg ? -ez0 : (ez0 - G_ONE);
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready         = (state_reg == F_IDLE);
    assign div_req.start    = (state_reg == F_DIVGO);
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dvs_reg;

    assign push             = (state_reg == F_PUSH) && !q_full;
    assign push_job.maj     = maj_reg;
    assign push_job.mid     = mid_reg;
    assign push_job.mnr     = mnr_reg;
    assign push_job.x       = x_reg;
    assign push_job.x1      = x1_reg;
    assign push_job.y       = y_reg;
    assign push_job.z       = z_reg;
    assign push_job.dy_neg  = dyneg_reg;
    assign push_job.dz_neg  = dzneg_reg;
    assign push_job.ey      = ey_reg;
    assign push_job.ez      = ez_reg;
    assign push_job.ey_step = ERR_W'(edy_reg) << FRAC_BITS;
    assign push_job.ez_step = ERR_W'(edz_reg) << FRAC_BITS;
    assign push_job.colour  = colour_reg;

endmodule

`default_nettype wire

// ----- src/vlcs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-entry job queue between setup and stepping.
module vlcs_queue
    import vlcs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  job_t       push_job,
    output logic       full,
    input  wire logic  pop,
    output job_t       pop_job,
    output logic       empty
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

// ----- src/vlcs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Back end: error-term DDA along the major axis. One found voxel is held back
// so the final one of a segment can carry the last flag.
module vlcs_back
    import vlcs_pkg::*;
#(
    parameter int SIZE_X    = 64,
    parameter int SIZE_Y    = 64,
    parameter int SIZE_Z    = 64,
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  job_t                      q_job,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [IDX_W-1:0]          voxel_addr,
    output logic [COLOUR_W-1:0]       voxel_colour,
    output logic                      last_voxel
);

    localparam coord_t ONE   = coord_t'(1 << FRAC_BITS);
    localparam err_t   G_ONE = err_t'(64'd1 << (3 * FRAC_BITS));

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_ADJ  = 4'b0010,
        B_VOX  = 4'b0100,
        B_DONE = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;

    job_t                job_reg;
    coord_t              x_reg, y_reg, z_reg;
    err_t                ey_reg, ez_reg;
    logic [CNT_W-1:0]    n_reg;
    logic                pend_valid_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic                out_last_reg;

    logic   run, adj_y, adj_z, out_free, hit, out_load, out_last;
    coord_t c0, c1, c2;
    logic [COORD_W-1:0] iv0, iv1, iv2;
    logic   in0, in1, in2;
    logic [IDX_W-1:0] idx;

    function automatic coord_t axis_pos(axis_t k, axis_t maj, axis_t mid,
                                        coord_t px, coord_t py, coord_t pz);
        coord_t r;
        if (maj == k)      r = px;
        else if (mid == k) r = py;
        else               r = pz;
        return r;
    endfunction

    // integer part truncated toward zero; anything in (-1, 0) is voxel 0
    function automatic logic [COORD_W-1:0] ipart(coord_t v);
        return v[COORD_W-1] ? '0 : COORD_W'(v >>> FRAC_BITS);
    endfunction

    assign run      = (x_reg < job_reg.x1) && (n_reg < MAX_OUT);
    assign adj_y    = (ey_reg > 0);
    assign adj_z    = (ez_reg > 0);
    assign out_free = !out_valid_reg || out_ready;

    assign c0  = axis_pos(AX_X, job_reg.maj, job_reg.mid, x_reg, y_reg, z_reg);
    assign c1  = axis_pos(AX_Y, job_reg.maj, job_reg.mid, x_reg, y_reg, z_reg);
    assign c2  = axis_pos(AX_Z, job_reg.maj, job_reg.mid, x_reg, y_reg, z_reg);
    assign iv0 = ipart(c0);
    assign iv1 = ipart(c1);
    assign iv2 = ipart(c2);
    assign in0 = (c0 > -ONE) && (iv0 < COORD_W'(SIZE_X));
    assign in1 = (c1 > -ONE) && (iv1 < COORD_W'(SIZE_Y));
    assign in2 = (c2 > -ONE) && (iv2 < COORD_W'(SIZE_Z));
    assign hit = in0 && in1 && in2;
    assign idx = IDX_W'(iv0) + IDX_W'(iv1) * IDX_W'(SIZE_X)
               + IDX_W'(iv2) * IDX_W'(SIZE_X * SIZE_Y);

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        out_last   = 1'b0;
        unique case (state_reg)
            B_IDLE:
                if (!q_empty)
                    state_next = B_ADJ;
            B_ADJ:
                if (!run)
                    state_next = B_DONE;
                else if (!adj_y && !adj_z)
                    state_next = B_VOX;
            B_VOX:
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    state_next = B_ADJ;
                    out_load   = hit && pend_valid_reg;
                end
            B_DONE:
                if (!pend_valid_reg)
                    state_next = B_IDLE;
                else if (out_free)
                begin
                    state_next = B_IDLE;
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                end
            default:
                state_next = B_IDLE;
        endcase
    end

    assign pop = (state_reg == B_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (pop)
                n_reg <= '0;
            else if (state_reg == B_VOX && state_next == B_ADJ && hit)
                n_reg <= n_reg + 1'b1;
            if (state_reg == B_VOX && state_next == B_ADJ && hit)
                pend_valid_reg <= 1'b1;
            else if (state_reg == B_DONE && state_next == B_IDLE)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
            x_reg   <= q_job.x;
            y_reg   <= q_job.y;
            z_reg   <= q_job.z;
            ey_reg  <= q_job.ey;
            ez_reg  <= q_job.ez;
        end
        else if (state_reg == B_ADJ && run)
        begin
            if (adj_y)
            begin
                y_reg  <= job_reg.dy_neg ? (y_reg - ONE) : (y_reg + ONE);
                ey_reg <= ey_reg - G_ONE;
            end
            if (adj_z)
            begin
                z_reg  <= job_reg.dz_neg ? (z_reg - ONE) : (z_reg + ONE);
                ez_reg <= ez_reg - G_ONE;
            end
        end
        else if (state_reg == B_VOX && state_next == B_ADJ)
        begin
            x_reg  <= x_reg + ONE;
            ey_reg <= ey_reg + job_reg.ey_step;
            ez_reg <= ez_reg + job_reg.ez_step;
            if (hit)
                pend_idx_reg <= idx;
        end

        if (out_load)
        begin
            out_idx_reg    <= pend_idx_reg;
            out_colour_reg <= job_reg.colour;
            out_last_reg   <= out_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign voxel_addr   = out_idx_reg;
    assign voxel_colour = out_colour_reg;
    assign last_voxel   = out_last_reg;

`ifndef SYNTHESIS
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_OUT)
        else $error("voxel count past cap");
    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pend_valid_reg) |-> (out_valid_reg && out_last_reg))
        else $error("held voxel dropped without last flag");
    a_pend_new_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !pend_valid_reg)
        else $error("held voxel left over at job start");
`endif

endmodule

`default_nettype wire

// ----- src/voxel_line_clip_and_step_unit.sv -----
// Channel   Dir  Handshake            Payload
// ---------------------------------------------------------------------------
// segment   in   in_valid/in_ready    start_x/y/z, end_x/y/z (s18), line_colour (8)
// voxel     out  out_valid/out_ready  voxel_addr (18), voxel_colour (8), last_voxel
//
// Setup runs its divisions one at a time in the shared divider, a clip division
// adding a product step: two per clipped face (up to 12) and two for the slopes.
// Stepping visits B_ADJ and B_VOX for each major-axis step and stays in B_ADJ
// while minor carries are pending (y and z carry together).
// Setup of the next segment overlaps stepping of the current one (2-deep queue).
// Reset is asynchronous and clears control only; no clearing pass.
// A stalled voxel port holds one result in the output register and one held
// back voxel; stepping pauses only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module voxel_line_clip_and_step_unit
    import vlcs_pkg::*;
#(
    parameter int SIZE_X    = 64,
    parameter int SIZE_Y    = 64,
    parameter int SIZE_Z    = 64,
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [17:0]   start_x,
    input  wire logic signed [17:0]   start_y,
    input  wire logic signed [17:0]   start_z,
    input  wire logic signed [17:0]   end_x,
    input  wire logic signed [17:0]   end_y,
    input  wire logic signed [17:0]   end_z,
    input  wire logic [COLOUR_W-1:0]  line_colour,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [IDX_W-1:0]          voxel_addr,
    output logic [COLOUR_W-1:0]       voxel_colour,
    output logic                      last_voxel
);

    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     push, q_full, pop, q_empty;
    job_t     push_job, pop_job;

    // front end: clip, major axis, slopes, initial error terms
    vlcs_front #(
        .SIZE_X    (SIZE_X),
        .SIZE_Y    (SIZE_Y),
        .SIZE_Z    (SIZE_Z),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .start_z     (start_z),
        .end_x       (end_x),
        .end_y       (end_y),
        .end_z       (end_z),
        .line_colour (line_colour),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .push        (push),
        .push_job    (push_job),
        .q_full      (q_full)
    );

    // shared bit-serial divider
    vlcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // decouples setup from stepping
    vlcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // back end: DDA stepper and output beat register
    vlcs_back #(
        .SIZE_X    (SIZE_X),
        .SIZE_Y    (SIZE_Y),
        .SIZE_Z    (SIZE_Z),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .voxel_addr   (voxel_addr),
        .voxel_colour (voxel_colour),
        .last_voxel   (last_voxel)
    );

endmodule

`default_nettype wire

// ----- tb/sv/voxel_line_clip_and_step_unit_tb.sv -----
`timescale 1ns / 1ps

module voxel_line_clip_and_step_unit_tb;
    import vlcs_pkg::*;

    // Block configuration (defaults of the top level)
    localparam int     SX    = 64;
    localparam int     SY    = 64;
    localparam int     SZ    = 64;
    localparam int     FB    = 8;
    localparam longint ONE   = longint'(1) << FB;
    localparam int     VOX_CAP = 64;
    // Cycles with no beat on either side before the run is declared hung.
    localparam int     HANG_LIMIT = 40000;
    localparam int     DRAIN_CYCLES = 1500;

    // Directed rows: either checked against the predictor or typed in
    localparam int ROW_PREDICT = 0;
    localparam int ROW_NONE    = 1;
    localparam int ROW_SINGLE  = 2;

    typedef struct {
        logic [IDX_W-1:0]    idx;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } voxel_t;

    typedef struct {
        int               sx, sy, sz, ex, ey, ez;
        logic [7:0]       colour;
        int               kind;
        logic [IDX_W-1:0] idx;
    } seg_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [17:0]      start_x, start_y, start_z;
    logic signed [17:0]      end_x, end_y, end_z;
    logic [COLOUR_W-1:0]     line_colour;
    logic                    out_valid;
    logic                    out_ready;
    logic [IDX_W-1:0]        voxel_addr;
    logic [COLOUR_W-1:0]     voxel_colour;
    logic                    last_voxel;

    voxel_t voxel_q[$];      // voxels still owed by the block
    int     mismatches;
    int     idle_cycles;
    int     send_gap_pct;    // sender idle percentage of the current phase
    int     stall_pct;       // receiver stall percentage of the current phase
    int     hold_cycles;     // long receiver hold-off request
    int     rx_hold;

    voxel_line_clip_and_step_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .line_colour  (line_colour),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .voxel_addr   (voxel_addr),
        .voxel_colour (voxel_colour),
        .last_voxel   (last_voxel)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Integer part truncated toward zero
    function automatic longint trunc_int(input longint v);
        return (v >= 0) ? (v >>> FB) : -((-v) >>> FB);
    endfunction

    function automatic longint frac_of(input longint v);
        return v - trunc_int(v) * ONE;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint axis_size(input int a);
        return (a == 0) ? SX : (a == 1) ? SY : SZ;
    endfunction

    function automatic longint axis_stride(input int a);
        return (a == 0) ? 1 : (a == 1) ? SX : longint'(SX) * SY;
    endfunction

    // Clip both endpoints on axis c against [0, m]; 1 means fully outside
    function automatic bit clip_face(inout longint a[3], inout longint b[3],
                                     input int c, input longint m);
        longint lo[3];
        longint hi[3];
        longint dl[3];
        longint num;
        longint den;
        bit     sw;
        sw = a[c] > b[c];
        for (int k = 0; k < 3; k++)
        begin
            lo[k] = sw ? b[k] : a[k];
            hi[k] = sw ? a[k] : b[k];
        end
        if (hi[c] < 0 || lo[c] > m)
            return 1'b1;
        if (lo[c] < 0)
        begin
            for (int k = 0; k < 3; k++) dl[k] = hi[k] - lo[k];
            num = -lo[c];
            den = dl[c];
            for (int k = 0; k < 3; k++) lo[k] += dl[k] * num / den;
        end
        if (hi[c] > m)
        begin
            for (int k = 0; k < 3; k++) dl[k] = hi[k] - lo[k];
            num = hi[c] - m;
            den = dl[c];
            for (int k = 0; k < 3; k++) hi[k] -= dl[k] * num / den;
        end
        for (int k = 0; k < 3; k++)
        begin
            a[k] = sw ? hi[k] : lo[k];
            b[k] = sw ? lo[k] : hi[k];
        end
        return 1'b0;
    endfunction

    // Walk one segment and queue the voxels it lights
    task automatic predict_line(input int sx, input int sy, input int sz,
                                input int ex, input int ey, input int ez,
                                input logic [7:0] col);
        longint p0[3];
        longint p1[3];
        longint s[3];
        longint e[3];
        longint dd[3];
        int     ch[3];
        int     t;
        int     n;
        longint x, y, z, x1, dx, dy, dz, sy_, sz_, erry, errz, half, fx;
        longint ix, iy, iz;
        longint gone;
        voxel_t v;
        n = 0;
        gone = longint'(1) << (3 * FB);
        p0[0] = sx; p0[1] = sy; p0[2] = sz;
        p1[0] = ex; p1[1] = ey; p1[2] = ez;
        for (int k = 0; k < 3; k++)
            if (clip_face(p0, p1, k, (axis_size(k) - 1) * ONE))
                return;
        for (int k = 0; k < 3; k++) dd[k] = mag(p0[k] - p1[k]);
        ch[0] = 0; ch[1] = 1; ch[2] = 2;
        // ties favor z, then y
        if (dd[ch[1]] > dd[ch[2]]) begin t = ch[1]; ch[1] = ch[2]; ch[2] = t; end
        if (dd[ch[0]] > dd[ch[2]]) begin t = ch[0]; ch[0] = ch[2]; ch[2] = t; end
        for (int k = 0; k < 3; k++)
        begin
            s[k] = (p0[ch[2]] < p1[ch[2]]) ? p0[k] : p1[k];
            e[k] = (p0[ch[2]] < p1[ch[2]]) ? p1[k] : p0[k];
        end
        x = s[ch[2]]; x1 = e[ch[2]];
        y = s[ch[1]]; z = s[ch[0]];
        dx = x1 - x;
        dy = e[ch[1]] - y;
        dz = e[ch[0]] - z;
        if (dx <= 0)
            return;
        sy_ = (mag(dy) <<< (2 * FB)) / dx;
        sz_ = (mag(dz) <<< (2 * FB)) / dx;
        half = longint'(1) << (FB - 1);
        fx = frac_of(x);
        erry = (half - fx) * sy_ + frac_of(y) * (longint'(1) << (2 * FB));
        if (dy >= 0) erry -= gone; else erry = -erry;
        errz = (half - fx) * sz_ + frac_of(z) * (longint'(1) << (2 * FB));
        if (dz >= 0) errz -= gone; else errz = -errz;
        sy_ = sy_ <<< FB;
        sz_ = sz_ <<< FB;
        while (x < x1 && n < VOX_CAP)
        begin
            while (erry > 0) begin y += (dy >= 0) ? ONE : -ONE; erry -= gone; end
            while (errz > 0) begin z += (dz >= 0) ? ONE : -ONE; errz -= gone; end
            ix = trunc_int(x);
            iy = trunc_int(y);
            iz = trunc_int(z);
            // voxels stepped off the box are skipped, not counted
            if (ix >= 0 && ix < axis_size(ch[2]) && iy >= 0 && iy < axis_size(ch[1]) &&
                iz >= 0 && iz < axis_size(ch[0]))
            begin
                v.idx    = IDX_W'(ix * axis_stride(ch[2]) + iy * axis_stride(ch[1]) +
                                  iz * axis_stride(ch[0]));
                v.colour = col;
                v.last   = 1'b0;
                voxel_q.push_back(v);
                n++;
            end
            x += ONE;
            erry += sy_;
            errz += sz_;
        end
        if (n > 0)
            voxel_q[voxel_q.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Segment sender: holds valid and payload until the beat is taken
    // ------------------------------------------------------------------
    task automatic send_line(input seg_row_t r);
        voxel_t v;
        in_valid    <= 1'b1;
        start_x     <= 18'(r.sx);
        start_y     <= 18'(r.sy);
        start_z     <= 18'(r.sz);
        end_x       <= 18'(r.ex);
        end_y       <= 18'(r.ey);
        end_z       <= 18'(r.ez);
        line_colour <= r.colour;
        do @(posedge clk); while (!in_ready);
        case (r.kind)
            ROW_NONE: ;
            ROW_SINGLE:
            begin
                v.idx = r.idx; v.colour = r.colour; v.last = 1'b1;
                voxel_q.push_back(v);
            end
            default: predict_line(r.sx, r.sy, r.sz, r.ex, r.ey, r.ez, r.colour);
        endcase
    endtask

    // Idle gap after a beat; lowers valid only when a gap is taken
    task automatic sender_gap();
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Random segment: mostly inside or near the box, some raw 18-bit noise
    function automatic seg_row_t random_line();
        seg_row_t r;
        int       sel;
        int       span;
        sel = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? 20000 : 3000;
        r.sx = $urandom_range(0, 17000) - 300;
        r.sy = $urandom_range(0, 17000) - 300;
        r.sz = $urandom_range(0, 17000) - 300;
        r.ex = r.sx + $urandom_range(0, 2 * span) - span;
        r.ey = r.sy + $urandom_range(0, 2 * span) - span;
        r.ez = r.sz + $urandom_range(0, 2 * span) - span;
        if (sel < 15)
        begin
            r.sx = int'($signed(18'($urandom))); r.sy = int'($signed(18'($urandom)));
            r.sz = int'($signed(18'($urandom))); r.ex = int'($signed(18'($urandom)));
            r.ey = int'($signed(18'($urandom))); r.ez = int'($signed(18'($urandom)));
        end
        else if (sel < 22)
        begin
            // axis-aligned or tied extents
            r.ey = r.sy + ((sel & 1) ? (r.ex - r.sx) : 0);
            r.ez = r.sz + ((sel & 2) ? (r.ex - r.sx) : 0);
        end
        r.colour = 8'($urandom);
        r.kind   = ROW_PREDICT;
        r.idx    = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver ready: random stalls, plus a long counted hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end
        else if (hold_cycles > 0 && rx_hold == 0)
        begin
            rx_hold   <= hold_cycles;
            out_ready <= 1'b0;
        end
        else if (rx_hold > 1)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_hold   <= 0;
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Voxel checker and hang watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        voxel_t w;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (voxel_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected voxel beat: idx %0d colour %0d last %0b",
                                 voxel_addr, voxel_colour, last_voxel);
                    mismatches++;
                end
                else
                begin
                    w = voxel_q.pop_front();
                    if (voxel_addr !== w.idx || voxel_colour !== w.colour ||
                        last_voxel !== w.last)
                    begin
                        if (mismatches < 10)
                            $display({"voxel mismatch: exp idx %0d colour %0d last %0b,",
                                      " got idx %0d colour %0d last %0b"},
                                     w.idx, w.colour, w.last,
                                     voxel_addr, voxel_colour, last_voxel);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    seg_row_t directed[] = '{
        // fully outside: below and above on each axis
        '{-131072, -131072, -131072, -131072, -131072, -131072, 8'h00, ROW_NONE, 0},
        '{131071, 131071, 131071, 131071, 131071, 131071, 8'hFF, ROW_NONE, 0},
        '{-131072, 100, 100, -256, 5000, 5000, 8'h11, ROW_NONE, 0},
        '{100, 17000, 100, 5000, 131071, 5000, 8'h12, ROW_NONE, 0},
        '{100, 100, -900, 5000, 5000, -1, 8'h13, ROW_NONE, 0},
        // zero major span
        '{1000, 2000, 3000, 1000, 2000, 3000, 8'h21, ROW_NONE, 0},
        // one voxel at (1,1,1)
        '{256, 256, 256, 512, 256, 256, 8'hAA, ROW_SINGLE, 1 + SX + SX * SY},
        // axis-aligned along each axis, both directions
        '{0, 0, 0, 16128, 0, 0, 8'h31, ROW_PREDICT, 0},
        '{0, 16128, 0, 0, 0, 0, 8'h32, ROW_PREDICT, 0},
        '{16383, 16383, 0, 16383, 16383, 16383, 8'h33, ROW_PREDICT, 0},
        // full-box diagonals and ties between extents
        '{0, 0, 0, 16383, 16383, 16383, 8'h41, ROW_PREDICT, 0},
        '{16383, 0, 16383, 0, 16383, 0, 8'h42, ROW_PREDICT, 0},
        '{100, 200, 300, 4100, 4200, 300, 8'h43, ROW_PREDICT, 0},
        '{100, 200, 300, 4100, 200, 4300, 8'h44, ROW_PREDICT, 0},
        // clipped on several faces, through the extremes
        '{-131072, -131072, -131072, 131071, 131071, 131071, 8'h51, ROW_PREDICT, 0},
        '{131071, -131072, 5000, -131072, 131071, 9000, 8'h52, ROW_PREDICT, 0},
        '{-3000, 8000, 20000, 20000, 9000, -4000, 8'h53, ROW_PREDICT, 0},
        // fractional starts, negative minor deltas
        '{1055, 9001, 7777, 9999, 3333, 1234, 8'h61, ROW_PREDICT, 0},
        '{127, 128, 129, 900, 129, 128, 8'h62, ROW_PREDICT, 0},
        // short segments hugging the far edge (steps off the box)
        '{16200, 16300, 16383, 16383, 16100, 16383, 8'h71, ROW_PREDICT, 0},
        '{0, 1, 16383, 200, 255, 16383, 8'h72, ROW_PREDICT, 0}
    };

    initial
    begin
        seg_row_t r;
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        start_x      <= '0;
        start_y      <= '0;
        start_z      <= '0;
        end_x        <= '0;
        end_y        <= '0;
        end_z        <= '0;
        line_colour  <= '0;
        mismatches   = 0;
        idle_cycles  = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_cycles  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back
        foreach (directed[i])
            send_line(directed[i]);

        // random phases: none / sender idle / receiver stall / both light
        for (int ph = 0; ph < 4; ph++)
        begin
            send_gap_pct = (ph == 1) ? 84 : (ph == 3) ? 16 : 0;
            stall_pct    = (ph == 2) ? 84 : (ph == 3) ? 16 : 0;
            for (int i = 0; i < 77; i++)
            begin
                if (ph == 0 && i == 10)
                    hold_cycles = 3000;     // block fills and stalls its input
                if (ph == 0 && i == 11)
                    hold_cycles = 0;        // one hold-off only, already latched
                if (ph == 3 && i == 40)
                begin
                    // sender pauses until every voxel owed has come back
                    in_valid <= 1'b0;
                    while (voxel_q.size() != 0) @(posedge clk);
                    repeat (800) @(posedge clk);
                end
                r = random_line();
                send_line(r);
                sender_gap();
            end
        end
        in_valid <= 1'b0;

        while (voxel_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && voxel_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
